### design/scrolling_text_terminal_buffer_defines.svh
// Assertion macros for the scrolling text terminal buffer
`ifndef SCROLLING_TEXT_TERMINAL_BUFFER_DEFINES_SVH
`define SCROLLING_TEXT_TERMINAL_BUFFER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define STT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/stt_pkg.sv
// Shared types, key codes and prompt text for the scrolling text terminal buffer
package stt_pkg;

  typedef enum logic {
    ACT_KEY  = 1'b0,
    ACT_READ = 1'b1
  } stt_act_e;

  localparam logic [7:0] KEY_BS  = 8'h08;
  localparam logic [7:0] KEY_DEL = 8'h7F;
  localparam logic [7:0] KEY_LF  = 8'h0A;
  localparam logic [7:0] KEY_CR  = 8'h0D;

  localparam int PROMPT_FULL = 9;
  localparam int PW          = 4;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  function automatic logic [7:0] prompt_char(input logic [PW-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h44;
      4'd1:    c = 8'h69;
      4'd2:    c = 8'h67;
      4'd3:    c = 8'h69;
      4'd4:    c = 8'h74;
      4'd5:    c = 8'h65;
      4'd6:    c = 8'h2E;
      4'd7:    c = 8'h2E;
      4'd8:    c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### design/scrolling_text_terminal_buffer.sv
// Scrolling text terminal buffer: screen store, cursor and prompt tracking
//
// Input stream (s_axis): tuser selects the transaction kind, 0 = key byte,
// 1 = read one screen cell; tdata carries the key byte and the read position.
// Output stream (m_axis): one result per input transaction with cursor
// position, scroll flag, the read cell (0 for key bytes) and prompt status.
// An accepted input is registered in the input stage, its result in the result stage.
// Throughput: one transaction per cycle while m_axis_tready is high. A key byte updates
// the cursor and, unless newline or erase, writes a RAM cell; a read is one registered
// RAM read. Scrolling rotates the top line and clears its length and prompt count.
// Reset: line 0 shows the prompt "Digite...", cursor at line 0, column 9,
// other lines empty. The screen RAM itself is not cleared; line lengths and
// a prompt-cell count keep stale cells from ever being read.
// Stall: when the receiver holds tready low the result register and the
// input register both hold, and s_axis_tready drops once both are full.
module scrolling_text_terminal_buffer #(
  parameter int ROWS = 3,
  parameter int COLS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // key_byte[7:0], read_row[9:8], read_col[13:10]
  input  logic        s_axis_tuser,   // action[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // cursor_row[1:0], cursor_col[5:2], scrolled[6],
                                      // cell_char[14:7], prompt_showing[15]
);
  import stt_pkg::*;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLS + 1);
  localparam int CI    = $clog2(COLS);
  localparam int RCW   = (CW > 4) ? CW : 4;
  localparam int SW    = ROW_W + 3;
  localparam int AW    = $clog2(ROWS * COLS);
  localparam int PLEN  = (PROMPT_FULL < COLS) ? PROMPT_FULL : COLS;

  function automatic logic [ROW_W-1:0] phys_of(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    r = (v >= SW'(ROWS)) ? v - SW'(ROWS) : v;
    return r[ROW_W-1:0];
  endfunction

  // input stage
  logic                  v1_q;
  stt_act_e              in_act_q;
  logic [7:0]            in_key_q;
  logic [1:0]            in_rrow_q;
  logic [3:0]            in_rcol_q;

  // result stage
  logic                  v2_q;
  logic [1:0]            out_row_q;
  logic [3:0]            out_col_q;
  logic                  out_scr_q;
  logic                  out_prm_q;
  logic                  rd_ok_q;
  logic                  use_prm_q;
  logic [7:0]            prm_char_q;
  logic [7:0]            rd_data_q;

  // terminal state
  logic [ROW_W-1:0]      top_q, top_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [CW-1:0]         col_q, col_d;
  logic [CW-1:0]         len_q  [ROWS];
  logic [CW-1:0]         len_d  [ROWS];
  logic [PW-1:0]         mlen_q [ROWS];
  logic [PW-1:0]         mlen_d [ROWS];
  logic [PW-1:0]         orig_q, orig_d;
  logic                  prm_q, prm_d;

  logic [7:0]            mem_q [ROWS*COLS];

  logic                  adv2, step_en, key_en, rd_en, wr_en, wr_req;
  logic                  nl, scr;
  logic [ROW_W-1:0]      cur_p;
  logic [CW-1:0]         wr_col;
  logic [AW-1:0]         wr_addr, rd_addr;

  logic [ROW_W-1:0]      r_p;
  logic                  r_rowok, r_ok, r_use_prm;
  logic [RCW-1:0]        rcol_x;
  logic [7:0]            cell_byte;

  assign adv2          = !v2_q || m_axis_tready;
  assign s_axis_tready = !v1_q || adv2;
  assign step_en       = v1_q && adv2;
  assign key_en        = step_en && (in_act_q == ACT_KEY);
  assign rd_en         = step_en && (in_act_q == ACT_READ);
  assign wr_en         = key_en && wr_req;

  assign cur_p = phys_of(SW'(top_q) + SW'(row_q));

  always_comb begin
    top_d  = top_q;
    row_d  = row_q;
    col_d  = col_q;
    len_d  = len_q;
    mlen_d = mlen_q;
    orig_d = orig_q;
    wr_req = 1'b0;
    wr_col = col_q;
    nl     = 1'b0;
    scr    = 1'b0;
    if (prm_q) begin
      len_d[top_q]  = '0;
      mlen_d[top_q] = '0;
      col_d         = '0;
    end
    if (in_key_q == KEY_LF || in_key_q == KEY_CR) begin
      nl = 1'b1;
    end else if (in_key_q == KEY_BS || in_key_q == KEY_DEL) begin
      if (col_d != '0) begin
        col_d        = col_d - 1'b1;
        len_d[cur_p] = col_d;
        if (CW'(mlen_d[cur_p]) > col_d) begin
          mlen_d[cur_p] = PW'(col_d);
        end
      end
    end else begin
      wr_req = 1'b1;
      wr_col = col_d;
      if (CW'(mlen_d[cur_p]) == col_d && col_d < CW'(PLEN) &&
          in_key_q == prompt_char(PW'(col_d))) begin
        mlen_d[cur_p] = PW'(col_d + 1'b1);
      end
      if (cur_p == '0 && CW'(orig_q) > col_d) begin
        orig_d = PW'(col_d);
      end
      col_d        = col_d + 1'b1;
      len_d[cur_p] = col_d;
      if (col_d == CW'(COLS)) begin
        nl = 1'b1;
      end
    end
    if (nl) begin
      if (row_q == ROW_W'(ROWS - 1)) begin
        len_d[top_q]  = '0;
        mlen_d[top_q] = '0;
        top_d         = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
        scr           = 1'b1;
      end else begin
        row_d = row_q + 1'b1;
      end
      col_d = '0;
    end
    prm_d = (row_d == '0) && (len_d[top_d] == CW'(PLEN)) && (mlen_d[top_d] == PW'(PLEN));
  end

  // read path
  assign r_rowok   = int'(in_rrow_q) < ROWS;
  assign r_p       = phys_of(SW'(top_q) + SW'(in_rrow_q));
  assign rcol_x    = RCW'(in_rcol_q);
  assign r_ok      = r_rowok && (rcol_x < RCW'(COLS)) && (rcol_x < RCW'(len_q[r_p]));
  assign r_use_prm = (r_p == '0) && (rcol_x < RCW'(orig_q));
  assign rd_addr   = AW'(r_p) * AW'(COLS) + AW'(rcol_x[CI-1:0]);
  assign wr_addr   = AW'(cur_p) * AW'(COLS) + AW'(wr_col[CI-1:0]);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        v1_q <= s_axis_tvalid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_act_q  <= stt_act_e'(s_axis_tuser);
      in_key_q  <= s_axis_tdata[7:0];
      in_rrow_q <= s_axis_tdata[9:8];
      in_rcol_q <= s_axis_tdata[13:10];
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      if (in_act_q == ACT_KEY) begin
        out_row_q <= 2'(row_d);
        out_col_q <= 4'(col_d);
        out_scr_q <= scr;
        out_prm_q <= prm_d;
        rd_ok_q   <= 1'b0;
      end else begin
        out_row_q <= 2'(row_q);
        out_col_q <= 4'(col_q);
        out_scr_q <= 1'b0;
        out_prm_q <= prm_q;
        rd_ok_q   <= r_ok;
      end
      use_prm_q  <= r_use_prm;
      prm_char_q <= prompt_char(in_rcol_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      row_q  <= '0;
      col_q  <= CW'(PLEN);
      orig_q <= PW'(PLEN);
      prm_q  <= 1'b1;
      for (int i = 0; i < ROWS; i++) begin
        len_q[i]  <= (i == 0) ? CW'(PLEN) : '0;
        mlen_q[i] <= (i == 0) ? PW'(PLEN) : '0;
      end
    end else if (key_en) begin
      top_q  <= top_d;
      row_q  <= row_d;
      col_q  <= col_d;
      orig_q <= orig_d;
      prm_q  <= prm_d;
      len_q  <= len_d;
      mlen_q <= mlen_d;
    end
  end

  assign cell_byte     = rd_ok_q ? (use_prm_q ? prm_char_q : rd_data_q) : 8'h00;
  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {out_prm_q, cell_byte, out_scr_q, out_col_q, out_row_q};

`include "scrolling_text_terminal_buffer_defines.svh"

  `STT_ASSERT_NOW(a_prompt_on_top_line, prm_q, row_q == '0, "prompt flag set off line 0")
  `STT_ASSERT_NOW(a_cursor_at_line_end, 1'b1, len_q[cur_p] == col_q,
                  "cursor column differs from cursor line length")
  `STT_ASSERT_NEXT(a_scroll_at_bottom, key_en && scr, row_q == ROW_W'(ROWS - 1),
                   "scroll without cursor on bottom line")

endmodule

### verif/scrolling_text_terminal_buffer_checker.sv
// Checker for the scrolling text terminal buffer: screen predictor and result scoreboard
module scrolling_text_terminal_buffer_checker #(
  parameter int ROWS = 3,
  parameter int COLS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // key_byte[7:0], read_row[9:8], read_col[13:10]
  input  logic        s_axis_tuser,   // action[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // cursor_row[1:0], cursor_col[5:2], scrolled[6],
                                      // cell_char[14:7], prompt_showing[15]
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int PROMPT_LEN = (PROMPT_FULL < COLS) ? PROMPT_FULL : COLS;

  typedef struct packed {
    logic       prompt_showing;
    logic [7:0] cell_char;
    logic       scrolled;
    logic [3:0] cursor_col;
    logic [1:0] cursor_row;
  } term_status_t;

  string        prompt_txt = "Digite...";
  logic [7:0]   cells [ROWS][COLS];
  int           line_len [ROWS];
  int           top_line;
  int           cur_line;
  int           cur_col;
  bit           prompt_on;
  term_status_t status_q [$];

  function automatic int phys_line(input int vis);
    return (top_line + vis) % ROWS;
  endfunction

  function automatic bit line0_holds_prompt();
    int p;
    p = phys_line(0);
    if (cur_line != 0 || line_len[p] != PROMPT_LEN) return 1'b0;
    for (int i = 0; i < PROMPT_LEN; i++)
      if (cells[p][i] != prompt_txt[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void reset_screen();
    for (int r = 0; r < ROWS; r++) begin
      line_len[r] = 0;
      for (int c = 0; c < COLS; c++) cells[r][c] = '0;
    end
    for (int i = 0; i < PROMPT_LEN; i++) cells[0][i] = prompt_txt[i];
    line_len[0] = PROMPT_LEN;
    top_line    = 0;
    cur_line    = 0;
    cur_col     = PROMPT_LEN;
    prompt_on   = 1'b1;
  endfunction

  // move to the next line; at the bottom, scroll by rotating the top line and emptying the old top
  function automatic bit advance_line();
    bit scr;
    scr = 1'b0;
    if (cur_line >= ROWS - 1) begin
      line_len[top_line % ROWS] = 0;
      top_line = (top_line % ROWS + 1) % ROWS;
      cur_line = ROWS - 1;
      scr      = 1'b1;
    end else begin
      cur_line++;
    end
    cur_col = 0;
    return scr;
  endfunction

  function automatic term_status_t step_terminal(input stt_act_e act, input logic [7:0] key,
                                                 input logic [1:0] row, input logic [3:0] col);
    term_status_t st;
    int           p;
    st = '0;
    if (act == ACT_KEY) begin
      if (prompt_on) begin
        line_len[phys_line(0)] = 0;
        cur_col = 0;
      end
      p = phys_line(cur_line);
      if (key == KEY_LF || key == KEY_CR) begin
        st.scrolled = advance_line();
      end else if (key == KEY_BS || key == KEY_DEL) begin
        if (cur_col > 0) begin
          cur_col--;
          line_len[p] = cur_col;
        end
      end else begin
        if (cur_col < COLS) cells[p][cur_col] = key;
        cur_col++;
        line_len[p] = cur_col;
        if (cur_col >= COLS) st.scrolled = advance_line();
      end
      prompt_on = line0_holds_prompt();
    end else if (row < ROWS) begin
      p = phys_line(row);
      if (col < COLS && col < line_len[p]) st.cell_char = cells[p][col];
    end
    st.cursor_row     = cur_line[1:0];
    st.cursor_col     = cur_col[3:0];
    st.prompt_showing = prompt_on;
    return st;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    term_status_t got;
    term_status_t want;
    if (!rst_ni) begin
      reset_screen();
      status_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        status_q.push_back(step_terminal(stt_act_e'(s_axis_tuser), s_axis_tdata[7:0],
                                         s_axis_tdata[9:8], s_axis_tdata[13:10]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (status_q.size() == 0) begin
          $error("result transaction with nothing pending: %h", m_axis_tdata);
          errors_o++;
        end else begin
          want = status_q.pop_front();
          check_field("cursor_row", want.cursor_row, got.cursor_row);
          check_field("cursor_col", want.cursor_col, got.cursor_col);
          check_field("scrolled", want.scrolled, got.scrolled);
          check_field("cell_char", want.cell_char, got.cell_char);
          check_field("prompt_showing", want.prompt_showing, got.prompt_showing);
        end
      end
    end
    pending_o = status_q.size();
  end

endmodule

### verif/scrolling_text_terminal_buffer_test.sv
// Testbench top for the scrolling text terminal buffer: clock, reset, stimulus and verdict
module scrolling_text_terminal_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int ROWS           = 3;
  localparam int COLS           = 16;
  localparam int N_ITEMS        = 1350;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  int    errors;
  int    pending;
  int    sent_count;
  int    idle_cycles;
  bit    quiet;
  string prompt_txt = "Digite...";

  scrolling_text_terminal_buffer #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  scrolling_text_terminal_buffer_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] text_char();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [7:0] newline_key();
    return $urandom_range(0, 1) ? KEY_LF : KEY_CR;
  endfunction

  task automatic send_txn(input stt_act_e act, input logic [7:0] key,
                          input logic [1:0] row, input logic [3:0] col);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, col, row, key};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  task automatic key_press(input logic [7:0] key);
    send_txn(ACT_KEY, key, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
  endtask

  task automatic read_cell(input logic [1:0] row, input logic [3:0] col);
    send_txn(ACT_READ, 8'($urandom_range(0, 255)), row, col);
  endtask

  initial begin
    int pick;
    int len;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    quiet         = 1'b0;
    sent_count    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // prompt after reset, reads past the line end and past the last row
    read_cell(2'd0, 4'd0);
    read_cell(2'd0, 4'd8);
    read_cell(2'd0, 4'd9);
    read_cell(2'd3, 4'd15);
    // retyping the prompt brings it back
    for (int i = 0; i < PROMPT_FULL; i++) key_press(prompt_txt[i]);
    key_press(KEY_BS);
    key_press(KEY_BS);
    key_press(8'h00);
    key_press(8'hFF);
    read_cell(2'd0, 4'd0);
    read_cell(2'd0, 4'd1);
    key_press(KEY_DEL);
    key_press(KEY_LF);
    key_press(KEY_CR);
    key_press(KEY_LF);

    while (sent_count < N_ITEMS) begin
      if ($urandom_range(0, 7) == 0) quiet = !quiet;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        len = $urandom_range(1, COLS - 1);
        repeat (len) key_press(text_char());
        if ($urandom_range(0, 9) < 7) key_press(newline_key());
      end else if (pick < 42) begin
        len = $urandom_range(COLS, COLS + 4);
        repeat (len) key_press(text_char());
      end else if (pick < 52) begin
        len = $urandom_range(0, 4);
        repeat (len) key_press(text_char());
        len = $urandom_range(1, 6);
        repeat (len) key_press($urandom_range(0, 1) ? KEY_BS : KEY_DEL);
      end else if (pick < 78) begin
        len = $urandom_range(1, 8);
        repeat (len) read_cell(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
      end else if (pick < 90) begin
        len = $urandom_range(1, 6);
        repeat (len) key_press(8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) key_press(newline_key());
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int run;
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      run = $urandom_range(1, 20);
      repeat (run) @(posedge clk_i);
      stall = idle_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // watchdog: cycles without any transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

### filelist.f
+incdir+design
design/stt_pkg.sv
design/scrolling_text_terminal_buffer.sv
verif/scrolling_text_terminal_buffer_checker.sv
verif/scrolling_text_terminal_buffer_test.sv
